FILE: design/icrle_pkg.sv
// ----------------------------------------------------------------------------
// icrle_pkg
// Types and constants shared by the channel run-length encoder modules.
// ----------------------------------------------------------------------------
package icrle_pkg;

	// Largest run or literal block, in bytes.
	localparam int unsigned BLOCK_MAX_DEF = 127;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COUNT_W = 3;
	localparam int unsigned TOTAL_W = 16;

	// A run header is 0x80 + count - 3, which is count + 0x7D.
	localparam logic [BYTE_W-1:0] RUN_HDR_BIAS = 8'h7D;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_RUN,
		MODE_LIT
	} blk_mode_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_OP,
		SQ_RUN_HDR,
		SQ_RUN_VAL,
		SQ_LIT_HDR,
		SQ_LIT_EM,
		SQ_END
	} seq_state_t;

	// Sequencer to packer: one encoded byte, or the end of a burst.
	typedef struct packed {
		logic              put;
		logic [BYTE_W-1:0] data;
		logic              close;
		logic              done;
	} pk_req_t;

	// Packer to sequencer.
	typedef struct packed {
		logic can_put;
		logic can_close;
	} pk_stat_t;

endpackage

FILE: design/icrle_in_if.sv
// ----------------------------------------------------------------------------
// icrle_in_if
// Input channel of the encoder: one channel byte per request.
// ----------------------------------------------------------------------------
interface icrle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] sample;
	logic       last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink (input valid, input sample, input last_sample, output ready);
endinterface

FILE: design/icrle_out_if.sv
// ----------------------------------------------------------------------------
// icrle_out_if
// Output channel of the encoder: up to four encoded bytes per request.
// ----------------------------------------------------------------------------
interface icrle_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_a;
	logic [7:0]  byte_b;
	logic [7:0]  byte_c;
	logic [7:0]  byte_d;
	logic [2:0]  byte_count;
	logic        last_of_burst;
	logic        stream_done;
	logic [15:0] total_length;

	modport source (output valid, output byte_a, output byte_b, output byte_c,
		output byte_d, output byte_count, output last_of_burst, output stream_done,
		output total_length, input ready);
	modport sink (input valid, input byte_a, input byte_b, input byte_c,
		input byte_d, input byte_count, input last_of_burst, input stream_done,
		input total_length, output ready);
endinterface

FILE: design/icon_channel_rle_encoder.sv
// ----------------------------------------------------------------------------
// icon_channel_rle_encoder
// PackBits-style run-length encoder for one byte channel of a pixel stream.
// ----------------------------------------------------------------------------
// The input channel takes one channel byte per request; last_sample marks the
// final byte of a channel. The output channel carries the encoded bytes up to
// four per request. last_of_burst flags the final request caused by one input
// request, and stream_done flags the final request of the channel, whose
// total_length is the full encoded length, held at 0xFFFF if it overflows.
// Three or more equal bytes become a run (header 0x80+count-3, then the
// value); other bytes gather into a literal block (header count-1, then the
// bytes) held in a single-port-per-side synchronous memory.
// Timing: the sequencer handles one input request at a time and the input is
// ready only while it is idle. A request that only fills the lookahead window
// leaves the sequencer idle. Any other request goes through its code
// operations, the header and bytes of each block it writes out and, at the
// end, the close of its burst; the memory read port and the packer, which
// takes one byte per cycle while it has room for it, pace the bytes out.
// Reset clears the lookahead window, block state and byte counter; the
// literal memory needs no clearing since an entry is always written before
// it is read. After a last_sample request the block returns to that state.
// When the receiver stalls, the output register holds its request and the
// sequencer waits as soon as the packer has a full word it cannot hand on.
// ----------------------------------------------------------------------------
module icon_channel_rle_encoder #(
	parameter int unsigned MAX_BLOCK = icrle_pkg::BLOCK_MAX_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	icrle_in_if.sink  in_ch,
	icrle_out_if.source out_ch
);
	import icrle_pkg::*;

	localparam int unsigned AW    = $clog2(MAX_BLOCK);
	localparam int unsigned LEN_W = $clog2(MAX_BLOCK + 1);

	// Sequencer and block state.
	seq_state_t        state_q, state_d;
	blk_mode_t         mode_q, mode_d;
	logic [LEN_W-1:0]  run_len_q, run_len_d;
	logic [LEN_W-1:0]  lit_len_q, lit_len_d;
	logic [AW-1:0]     rd_idx_q, rd_idx_d;
	logic              adv_q, adv_d;
	logic              last_q;
	logic [BYTE_W-1:0] run_val_q, run_val_d;

	// Lookahead window: two bytes and a fill count.
	logic [BYTE_W-1:0] la0_q, la1_q;
	logic [1:0]        lav_q;

	// Pending code operations of the current request, consumed from entry 0.
	logic [BYTE_W-1:0] op_byte_q [3];
	logic [2:0]        op_trip_q;
	logic [1:0]        op_cnt_q;

	// Literal memory.
	logic [BYTE_W-1:0] lit_mem [MAX_BLOCK];
	logic [BYTE_W-1:0] rd_data_q;
	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [BYTE_W-1:0] wr_data;

	// Values loaded when a request is accepted.
	logic              accept, acc_trip, shift;
	logic [BYTE_W-1:0] acc_b [3];
	logic [2:0]        acc_t;
	logic [1:0]        acc_cnt, lav_d;
	logic [BYTE_W-1:0] la0_d, la1_d;

	logic [LEN_W-1:0]  run_inc, lit_inc;
	logic              have_op;

	pk_req_t  pk_req;
	pk_stat_t pk_stat;

	assign in_ch.ready = (state_q == SQ_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	// Turn one request into up to three code operations. The first one may
	// start a run; at the end of a channel the window is drained as plain bytes.
	always_comb begin
		acc_trip = (la0_q == la1_q) && (la1_q == in_ch.sample);
		acc_b[0] = in_ch.sample;
		acc_b[1] = in_ch.sample;
		acc_b[2] = in_ch.sample;
		acc_t    = '0;
		acc_cnt  = '0;
		la0_d    = la0_q;
		la1_d    = la1_q;
		lav_d    = lav_q;
		case (lav_q)
			2'd0: begin
				acc_cnt = in_ch.last_sample ? 2'd1 : 2'd0;
				la0_d   = in_ch.sample;
				lav_d   = 2'd1;
			end
			2'd1: begin
				acc_b[0] = la0_q;
				acc_cnt  = in_ch.last_sample ? 2'd2 : 2'd0;
				la1_d    = in_ch.sample;
				lav_d    = 2'd2;
			end
			default: begin
				acc_b[0] = la0_q;
				acc_t[0] = acc_trip;
				acc_b[1] = la1_q;
				acc_cnt  = in_ch.last_sample ? 2'd3 : 2'd1;
				la0_d    = la1_q;
				la1_d    = in_ch.sample;
				lav_d    = 2'd2;
			end
		endcase
		if (in_ch.last_sample) begin
			lav_d = 2'd0;
		end
	end

	assign have_op = (op_cnt_q != 2'd0);
	assign run_inc = run_len_q + LEN_W'(1);
	assign lit_inc = lit_len_q + LEN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SQ_IDLE;
			mode_q    <= MODE_IDLE;
			run_len_q <= '0;
			lit_len_q <= '0;
			rd_idx_q  <= '0;
			adv_q     <= 1'b0;
			last_q    <= 1'b0;
			lav_q     <= '0;
			op_cnt_q  <= '0;
		end else begin
			state_q   <= state_d;
			mode_q    <= mode_d;
			run_len_q <= run_len_d;
			lit_len_q <= lit_len_d;
			rd_idx_q  <= rd_idx_d;
			adv_q     <= adv_d;
			if (accept) begin
				last_q   <= in_ch.last_sample;
				lav_q    <= lav_d;
				op_cnt_q <= acc_cnt;
			end else if (shift) begin
				op_cnt_q <= op_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		run_val_q <= run_val_d;
		if (accept) begin
			la0_q     <= la0_d;
			la1_q     <= la1_d;
			op_byte_q <= acc_b;
			op_trip_q <= acc_t;
		end else if (shift) begin
			op_byte_q[0] <= op_byte_q[1];
			op_byte_q[1] <= op_byte_q[2];
			op_trip_q    <= {1'b0, op_trip_q[2:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lit_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= lit_mem[rd_addr];
		end
	end

	// Sequencer. A flush leaves the mode idle; with adv_q clear the same
	// operation is then taken again and opens the next block.
	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		run_len_d = run_len_q;
		lit_len_d = lit_len_q;
		run_val_d = run_val_q;
		rd_idx_d  = rd_idx_q;
		adv_d     = adv_q;
		shift     = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = lit_len_q[AW-1:0];
		wr_data   = op_byte_q[0];
		rd_en     = 1'b0;
		rd_addr   = '0;
		pk_req    = '0;
		pk_req.done = last_q;
		case (state_q)
			SQ_IDLE: begin
				if (accept && ((acc_cnt != 2'd0) || in_ch.last_sample)) begin
					state_d = SQ_OP;
				end
			end
			SQ_OP: begin
				if (!have_op) begin
					adv_d = 1'b0;
					if (last_q && (mode_q == MODE_RUN)) begin
						state_d = SQ_RUN_HDR;
					end else if (last_q && (mode_q == MODE_LIT)) begin
						state_d = SQ_LIT_HDR;
					end else begin
						state_d = SQ_END;
					end
				end else begin
					case (mode_q)
						MODE_RUN: begin
							if (op_byte_q[0] == run_val_q) begin
								run_len_d = run_inc;
								if (run_inc == LEN_W'(MAX_BLOCK)) begin
									adv_d   = 1'b1;
									state_d = SQ_RUN_HDR;
								end else begin
									shift = 1'b1;
								end
							end else begin
								adv_d   = 1'b0;
								state_d = SQ_RUN_HDR;
							end
						end
						MODE_LIT: begin
							if (op_trip_q[0]) begin
								adv_d   = 1'b0;
								state_d = SQ_LIT_HDR;
							end else begin
								wr_en     = 1'b1;
								lit_len_d = lit_inc;
								if (lit_inc == LEN_W'(MAX_BLOCK)) begin
									adv_d   = 1'b1;
									state_d = SQ_LIT_HDR;
								end else begin
									shift = 1'b1;
								end
							end
						end
						default: begin
							shift = 1'b1;
							if (op_trip_q[0]) begin
								mode_d    = MODE_RUN;
								run_val_d = op_byte_q[0];
								run_len_d = LEN_W'(1);
							end else begin
								mode_d    = MODE_LIT;
								wr_en     = 1'b1;
								wr_addr   = '0;
								lit_len_d = LEN_W'(1);
							end
						end
					endcase
					// Last operation of a request that needs no final flush.
					if (shift && (op_cnt_q == 2'd1) && !last_q) begin
						state_d = SQ_END;
					end
				end
			end
			SQ_RUN_HDR: begin
				if (pk_stat.can_put) begin
					pk_req.put  = 1'b1;
					pk_req.data = BYTE_W'(run_len_q) + RUN_HDR_BIAS;
					state_d     = SQ_RUN_VAL;
				end
			end
			SQ_RUN_VAL: begin
				if (pk_stat.can_put) begin
					pk_req.put  = 1'b1;
					pk_req.data = run_val_q;
					mode_d      = MODE_IDLE;
					run_len_d   = '0;
					shift       = adv_q;
					state_d     = SQ_OP;
				end
			end
			SQ_LIT_HDR: begin
				if (pk_stat.can_put) begin
					pk_req.put  = 1'b1;
					pk_req.data = BYTE_W'(lit_len_q) - BYTE_W'(1);
					rd_en       = 1'b1;
					rd_addr     = '0;
					rd_idx_d    = '0;
					state_d     = SQ_LIT_EM;
				end
			end
			SQ_LIT_EM: begin
				if (pk_stat.can_put) begin
					pk_req.put  = 1'b1;
					pk_req.data = rd_data_q;
					if ((LEN_W'(rd_idx_q) + LEN_W'(1)) < lit_len_q) begin
						rd_en    = 1'b1;
						rd_addr  = rd_idx_q + AW'(1);
						rd_idx_d = rd_idx_q + AW'(1);
					end else begin
						mode_d    = MODE_IDLE;
						lit_len_d = '0;
						shift     = adv_q;
						state_d   = SQ_OP;
					end
				end
			end
			SQ_END: begin
				if (pk_stat.can_close) begin
					pk_req.close = 1'b1;
					state_d      = SQ_IDLE;
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	icrle_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pk_req),
		.stat   (pk_stat),
		.out_ch (out_ch)
	);

	// Block lengths never pass the configured maximum.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(run_len_q <= LEN_W'(MAX_BLOCK)) && (lit_len_q <= LEN_W'(MAX_BLOCK)))
		else $error("block length beyond MAX_BLOCK");

	// An open literal block always holds at least one byte.
	a_lit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_LIT) |-> (lit_len_q != '0))
		else $error("literal block open but empty");

	// The sequencer only hands a byte to the packer when it has room.
	a_put_room: assert property (@(posedge clk) disable iff (!arst_n)
		pk_req.put |-> pk_stat.can_put)
		else $error("byte pushed while packer full");

	// After the end of a channel the block is back in its reset state.
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == SQ_IDLE) && last_q) |-> ((mode_q == MODE_IDLE) && (lav_q == 2'd0)))
		else $error("state left over after end of channel");

endmodule

FILE: design/icrle_packer.sv
// ----------------------------------------------------------------------------
// icrle_packer
// Collects encoded bytes four to a word and drives the output register.
// ----------------------------------------------------------------------------
module icrle_packer (
	input  logic              clk,
	input  logic              arst_n,
	input  icrle_pkg::pk_req_t  req,
	output icrle_pkg::pk_stat_t stat,
	icrle_out_if.source       out_ch
);
	import icrle_pkg::*;

	logic [BYTE_W-1:0]  pk_q [4];
	logic [COUNT_W-1:0] cnt_q;
	logic [TOTAL_W-1:0] emitted_q;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  byte_a_q, byte_b_q, byte_c_q, byte_d_q;
	logic [COUNT_W-1:0] count_q;
	logic               burst_end_q, done_q;
	logic [TOTAL_W-1:0] total_q;

	logic               out_free, load_full, load_close, load;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] total;

	// A full word is held back until the next byte shows it is not the last.
	assign out_free   = !out_valid_q || out_ch.ready;
	assign load_full  = req.put && (cnt_q == COUNT_W'(4));
	assign load_close = req.close && (cnt_q != '0);
	assign load       = load_full || load_close;

	assign sum   = {1'b0, emitted_q} + (TOTAL_W+1)'(cnt_q);
	assign total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

	assign stat.can_put   = (cnt_q != COUNT_W'(4)) || out_free;
	assign stat.can_close = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			emitted_q   <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (req.put) begin
				cnt_q <= (cnt_q == COUNT_W'(4)) ? COUNT_W'(1) : cnt_q + COUNT_W'(1);
			end else if (req.close) begin
				cnt_q <= '0;
			end
			if (req.close && req.done) begin
				emitted_q <= '0;
			end else if (load) begin
				emitted_q <= total;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.put) begin
			pk_q[cnt_q[1:0]] <= req.data;
		end
		if (load) begin
			byte_a_q    <= pk_q[0];
			byte_b_q    <= (cnt_q > COUNT_W'(1)) ? pk_q[1] : '0;
			byte_c_q    <= (cnt_q > COUNT_W'(2)) ? pk_q[2] : '0;
			byte_d_q    <= (cnt_q > COUNT_W'(3)) ? pk_q[3] : '0;
			count_q     <= cnt_q;
			burst_end_q <= load_close;
			done_q      <= load_close && req.done;
			total_q     <= total;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.byte_a        = byte_a_q;
	assign out_ch.byte_b        = byte_b_q;
	assign out_ch.byte_c        = byte_c_q;
	assign out_ch.byte_d        = byte_d_q;
	assign out_ch.byte_count    = count_q;
	assign out_ch.last_of_burst = burst_end_q;
	assign out_ch.stream_done   = done_q;
	assign out_ch.total_length  = total_q;

endmodule

FILE: test/icon_channel_rle_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// icon_channel_rle_encoder_tb
// Self-checking bench for the channel run-length encoder.
// ----------------------------------------------------------------------------
// Channel bytes are sent as requests on the input channel. At each accepted
// request, a behavioral coder in this bench works out the encoded words that
// the request must cause. Every word taken from the output channel is
// compared field by field with the oldest predicted word. Both sides idle at
// random. A watchdog ends the run if no request moves for too long.
// ----------------------------------------------------------------------------
module icon_channel_rle_encoder_tb;

	import icrle_pkg::*;

	// Cycles with no accepted request on either side before the run is given
	// up. The slowest legal gap is a flush of a full literal block while the
	// receiver stalls, which stays far below this.
	localparam int unsigned STALL_LIMIT = 2000;
	// Cycles to watch for stray words once every prediction has been met.
	localparam int unsigned TAIL_CYCLES = 300;
	localparam int unsigned RAND_ITEMS  = 70;

	// One channel byte waiting to be sent. When hold is set, the sender
	// first waits until every predicted word has come out.
	typedef struct {
		logic [7:0] sample;
		logic       last_sample;
		bit         hold;
	} chan_byte_t;

	// One encoded word as the output channel carries it.
	typedef struct packed {
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  b3;
		logic [2:0]  cnt;
		logic        burst_end;
		logic        chan_end;
		logic [15:0] total;
	} enc_word_t;

	logic clk;
	logic arst_n;

	icrle_in_if  in_ch ();
	icrle_out_if out_ch ();

	icon_channel_rle_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	chan_byte_t  tx_bytes[$];      // channel bytes not yet offered
	enc_word_t   pending_words[$]; // predicted words not yet seen

	int unsigned bytes_offered;
	int unsigned bytes_taken;
	int unsigned words_taken;
	int unsigned words_seen;
	int unsigned chans_done;
	int unsigned enc_bytes_seen;
	int unsigned err_cnt;
	int unsigned idle_cycles;
	int          in_gap;
	int          out_gap;

	// ------------------------------------------------------------------------
	// Behavioral coder. It mirrors the lookahead window, the open block and
	// the running byte count, and turns each accepted request into the list
	// of encoded bytes it releases, then into words of up to four bytes.
	// ------------------------------------------------------------------------
	logic [7:0]  win_q[2];
	int unsigned win_fill;
	blk_mode_t   cur_mode;
	logic [7:0]  run_byte;
	int unsigned run_cnt;
	logic [7:0]  lit_mem[BLOCK_MAX_DEF];
	int unsigned lit_cnt;
	logic [15:0] enc_total;
	logic [7:0]  burst_q[$];

	function void clear_coder();
		win_q[0]  = '0;
		win_q[1]  = '0;
		win_fill  = 0;
		cur_mode  = MODE_IDLE;
		run_byte  = '0;
		run_cnt   = 0;
		lit_cnt   = 0;
		enc_total = '0;
	endfunction

	function void close_run();
		burst_q.push_back(8'(run_cnt) + RUN_HDR_BIAS);
		burst_q.push_back(run_byte);
		cur_mode = MODE_IDLE;
		run_cnt  = 0;
	endfunction

	function void close_literal();
		burst_q.push_back(8'(lit_cnt - 1));
		for (int k = 0; k < lit_cnt; k++)
			burst_q.push_back(lit_mem[k]);
		cur_mode = MODE_IDLE;
		lit_cnt  = 0;
	endfunction

	// Codes the oldest byte of the window. A triple means that this byte and
	// the two after it are equal, so a run may start here.
	function void code_one(input logic [7:0] b, input bit triple);
		if (cur_mode == MODE_RUN) begin
			if (b == run_byte) begin
				run_cnt++;
				if (run_cnt >= BLOCK_MAX_DEF)
					close_run();
				return;
			end
			close_run();
		end else if (cur_mode == MODE_LIT) begin
			if (!triple) begin
				lit_mem[lit_cnt] = b;
				lit_cnt++;
				if (lit_cnt >= BLOCK_MAX_DEF)
					close_literal();
				return;
			end
			close_literal();
		end
		if (triple) begin
			cur_mode = MODE_RUN;
			run_byte = b;
			run_cnt  = 1;
		end else begin
			cur_mode   = MODE_LIT;
			lit_mem[0] = b;
			lit_cnt    = 1;
		end
	endfunction

	function void encode_sample(input logic [7:0] s, input logic fin);
		enc_word_t  w;
		logic [7:0] quad[4];
		int         n;
		int         sum;

		burst_q.delete();
		if (win_fill < 2) begin
			win_q[win_fill] = s;
			win_fill++;
		end else begin
			code_one(win_q[0], win_q[0] == win_q[1] && win_q[1] == s);
			win_q[0] = win_q[1];
			win_q[1] = s;
		end

		// At the end of a channel the last two bytes can start no run, and
		// whatever block is still open goes out.
		if (fin) begin
			for (int k = 0; k < win_fill; k++)
				code_one(win_q[k], 1'b0);
			if (cur_mode == MODE_RUN)
				close_run();
			else if (cur_mode == MODE_LIT)
				close_literal();
		end

		for (int pos = 0; pos < burst_q.size(); pos += 4) begin
			n = burst_q.size() - pos;
			if (n > 4)
				n = 4;
			for (int k = 0; k < 4; k++)
				quad[k] = (k < n) ? burst_q[pos + k] : 8'h00;
			sum       = int'(enc_total) + n;
			enc_total = (sum > 16'hFFFF) ? 16'hFFFF : 16'(sum);
			w.b0        = quad[0];
			w.b1        = quad[1];
			w.b2        = quad[2];
			w.b3        = quad[3];
			w.cnt       = 3'(n);
			w.burst_end = (pos + n >= burst_q.size());
			w.chan_end  = w.burst_end && fin;
			w.total     = enc_total;
			pending_words.push_back(w);
		end

		// A finished channel leaves the block as it was after reset.
		if (fin)
			clear_coder();
	endfunction

	// ------------------------------------------------------------------------
	// Idle draws. Every third stretch of 48 accepted bytes runs with no
	// idling on either side, so the block also sees back-to-back requests.
	// ------------------------------------------------------------------------
	function int pick_pause();
		if ((bytes_taken / 48) % 3 == 2)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	function void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_cnt++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Driver. Works at the falling edge. A request stays up until it is
	// accepted; the next one follows after its drawn pause, or right away so
	// that valid never drops between two requests when the pause is zero.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		chan_byte_t nxt;
		logic       drive_v;

		drive_v = in_ch.valid;
		if (arst_n) begin
			if (drive_v && bytes_taken == bytes_offered)
				drive_v = 1'b0;
			if (!drive_v) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (tx_bytes.size() > 0 &&
					(!tx_bytes[0].hold || pending_words.size() == 0)) begin
					nxt = tx_bytes.pop_front();
					in_ch.sample      <= nxt.sample;
					in_ch.last_sample <= nxt.last_sample;
					drive_v = 1'b1;
					bytes_offered++;
					in_gap = pick_pause();
				end
			end
		end
		in_ch.valid <= drive_v;
	end

	// Receiver: after each accepted word, ready stays low for a drawn number
	// of cycles.
	always @(negedge clk) begin
		logic rdy;

		rdy = 1'b1;
		if (words_taken != words_seen) begin
			words_seen = words_taken;
			out_gap    = pick_pause();
		end
		if (out_gap > 0) begin
			out_gap--;
			rdy = 1'b0;
		end
		out_ch.ready <= rdy;
	end

	// ------------------------------------------------------------------------
	// Monitor. Works at the rising edge. Output words are checked before the
	// input request of the same edge is predicted; the block registers its
	// output, so a word can never belong to a request accepted at that edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		enc_word_t want;

		if (arst_n && out_ch.valid && out_ch.ready) begin
			words_taken++;
			if (pending_words.size() == 0) begin
				$error("unexpected output word: count %0d, total %0d",
					out_ch.byte_count, out_ch.total_length);
				err_cnt++;
			end else begin
				want = pending_words.pop_front();
				check_field("byte_a", want.b0, out_ch.byte_a);
				check_field("byte_b", want.b1, out_ch.byte_b);
				check_field("byte_c", want.b2, out_ch.byte_c);
				check_field("byte_d", want.b3, out_ch.byte_d);
				check_field("byte_count", want.cnt, out_ch.byte_count);
				check_field("last_of_burst", want.burst_end, out_ch.last_of_burst);
				check_field("stream_done", want.chan_end, out_ch.stream_done);
				check_field("total_length", want.total, out_ch.total_length);
			end
			enc_bytes_seen += 32'(out_ch.byte_count);
			if (out_ch.stream_done)
				chans_done++;
		end
		if (arst_n && in_ch.valid && in_ch.ready) begin
			encode_sample(in_ch.sample, in_ch.last_sample);
			bytes_taken++;
		end
	end

	// Watchdog: counts cycles in which no request moves on either side.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout after %0d idle cycles", idle_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic add_byte(input logic [7:0] s, input logic fin, input bit hold);
		chan_byte_t item;

		item.sample      = s;
		item.last_sample = fin;
		item.hold        = hold;
		tx_bytes.push_back(item);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus and end of run.
	// ------------------------------------------------------------------------
	initial begin
		int unsigned rand_items;
		int          chan_len;
		int          style;
		logic [7:0]  b;
		logic [7:0]  prev_b;
		logic [7:0]  run_v;
		bit          hold;

		clk               = 1'b0;
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.sample      = '0;
		in_ch.last_sample = 1'b0;
		out_ch.ready      = 1'b0;
		bytes_offered     = 0;
		bytes_taken       = 0;
		words_taken       = 0;
		words_seen        = 0;
		chans_done        = 0;
		enc_bytes_seen    = 0;
		err_cnt           = 0;
		idle_cycles       = 0;
		in_gap            = 0;
		out_gap           = 0;
		clear_coder();

		// Directed channels. A one-byte channel ends before the window is
		// full; a two-byte channel ends with the window just full.
		add_byte(8'hA5, 1'b1, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0);
		add_byte(8'hFF, 1'b1, 1'b0);
		// Shortest run, ending right at the end of the channel.
		add_byte(8'h7E, 1'b0, 1'b0);
		add_byte(8'h7E, 1'b0, 1'b0);
		add_byte(8'h7E, 1'b1, 1'b0);
		// Literal bytes cut short by a run, then a pair that stays literal.
		add_byte(8'h00, 1'b0, 1'b0);
		add_byte(8'hFF, 1'b0, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0);
		add_byte(8'hFF, 1'b0, 1'b0);
		for (int i = 0; i < 5; i++)
			add_byte(8'h5A, 1'b0, 1'b0);
		add_byte(8'h81, 1'b0, 1'b0);
		add_byte(8'h81, 1'b0, 1'b0);
		add_byte(8'h3C, 1'b1, 1'b0);
		// A run that the channel end cuts with only two more equal bytes.
		for (int i = 0; i < 4; i++)
			add_byte(8'hFF, 1'b0, 1'b0);
		add_byte(8'h00, 1'b1, 1'b0);

		// One long channel: a run that fills a whole block and spills over,
		// then literal bytes with no two neighbors equal, enough to fill a
		// literal block and start another. The sender waits for an empty
		// pipeline before it starts.
		run_v = 8'($urandom_range(0, 255));
		for (int i = 0; i < BLOCK_MAX_DEF + 1; i++)
			add_byte(run_v, 1'b0, i == 0);
		prev_b = run_v;
		for (int i = 0; i < BLOCK_MAX_DEF + 1; i++) begin
			do
				b = 8'($urandom_range(0, 255));
			while (b == prev_b);
			add_byte(b, i == BLOCK_MAX_DEF, 1'b0);
			prev_b = b;
		end

		// Random channels of mixed styles: uniform bytes, bytes that repeat
		// often so that runs of many lengths form, and a two-value alphabet
		// at the byte extremes.
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			chan_len = $urandom_range(1, 30);
			style    = $urandom_range(0, 2);
			hold     = ($urandom_range(0, 3) == 0);
			prev_b   = 8'($urandom_range(0, 255));
			for (int i = 0; i < chan_len; i++) begin
				case (style)
					0: begin
						b = 8'($urandom_range(0, 255));
					end
					1: begin
						b = ($urandom_range(0, 3) != 0) ? prev_b : 8'($urandom_range(0, 255));
					end
					default: begin
						b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					end
				endcase
				add_byte(b, i == chan_len - 1, hold && i == 0);
				prev_b = b;
			end
			rand_items += chan_len;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (tx_bytes.size() > 0 || in_ch.valid || pending_words.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Coded %0d channel bytes in %0d channels, directed and random.",
			bytes_taken, chans_done);
		$display("Checked %0d output words holding %0d encoded bytes, %0d errors.",
			words_taken, enc_bytes_seen, err_cnt);
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
